FILE: design/nfa_pkg.sv
`timescale 1ns / 1ps
// Package: sizes, codes, command and config types, and set helpers for the NFA word acceptor.
package nfa_pkg;

  localparam int NUM_STATES  = 16;
  localparam int SYMBOL_BITS = 8;
  localparam int ST_W        = $clog2(NUM_STATES);
  localparam int ADDR_W      = SYMBOL_BITS + ST_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int FIELD_ST_W  = 4;
  localparam int FIELD_SYM_W = 8;
  localparam int OUT_SET_W   = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_STEP  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_STEP
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL = 2'd0,
    CFG_FINAL   = 2'd1,
    CFG_HIGHEST = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOAD_WR,
    BK_SCAN,
    BK_DRAIN,
    BK_REPORT
  } bk_state_t;

  typedef struct packed {
    op_t                    op;
    logic [ST_W-1:0]        from_st;
    logic [ST_W-1:0]        to_st;
    logic [SYMBOL_BITS-1:0] sym;
    logic                   last;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_ST_W-1:0] init_st;
    logic [CFG_W-1:0]      final_mask;
    logic [FIELD_ST_W-1:0] highest;
  } cfg_t;

  // states 0..min(highest, NUM_STATES-1)
  function automatic logic [NUM_STATES-1:0] keep_mask(logic [FIELD_ST_W-1:0] highest);
    int h;
    logic [NUM_STATES-1:0] m;
    h = int'(highest);
    if (h > NUM_STATES - 1) h = NUM_STATES - 1;
    for (int i = 0; i < NUM_STATES; i++) m[i] = (i <= h);
    return m;
  endfunction

  // one-hot of the initial state, empty when out of range
  function automatic logic [NUM_STATES-1:0] init_set(logic [FIELD_ST_W-1:0] init_st);
    logic [NUM_STATES-1:0] s;
    for (int i = 0; i < NUM_STATES; i++) s[i] = (int'(init_st) == i);
    return s;
  endfunction

endpackage

FILE: design/nfa_in_if.sv
`timescale 1ns / 1ps
// Input word channel: valid/ready handshake with request payload.
interface nfa_in_if;
  import nfa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [FIELD_ST_W-1:0]  from_state;
  logic [FIELD_ST_W-1:0]  to_state;
  logic [FIELD_SYM_W-1:0] symbol;
  logic                   last_symbol;

  modport source (output valid, req_type, from_state, to_state, symbol, last_symbol,
                  input ready);
  modport sink (input valid, req_type, from_state, to_state, symbol, last_symbol,
                output ready);
endinterface

FILE: design/nfa_out_if.sv
`timescale 1ns / 1ps
// Result word channel: valid/ready handshake with acceptance payload.
interface nfa_out_if;
  import nfa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [OUT_SET_W-1:0] active_states;

  modport source (output valid, accepted, active_states, input ready);
  modport sink (input valid, accepted, active_states, output ready);
endinterface

FILE: design/nfa_word_acceptor_unit.sv
`timescale 1ns / 1ps
// Top level of the NFA word acceptor: config registers, front end, command queue, back end.
// The block runs a nondeterministic automaton over byte words with one bit per state.
// After reset the transition store (4096 entries) is cleared; no word is accepted during that
// pass, configuration writes are. A load word does a read-modify-write of one store entry in
// the back end, and a start word loads the initial state set. A symbol word reads the
// successor masks of the 16 states in turn, since the store has one read port, and a drain
// state then adds in the mask of the last read. A start or symbol word with the last flag
// set then loads the result register. A two-entry queue lets the front end take new words
// while the back end works, and the result register holds a result until it is taken.
module nfa_word_acceptor_unit import nfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  nfa_in_if.sink               in_chan,
  nfa_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg_r;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t head;
  logic clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_st    <= '0;
      cfg_r.final_mask <= '0;
      cfg_r.highest    <= FIELD_ST_W'(15);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INITIAL: cfg_r.init_st    <= cfg_wdata[FIELD_ST_W-1:0];
        CFG_FINAL:   cfg_r.final_mask <= cfg_wdata;
        CFG_HIGHEST: cfg_r.highest    <= cfg_wdata[FIELD_ST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  nfa_front u_front (
    .clearing (clearing),
    .q_full   (q_full),
    .in_ch    (in_chan),
    .push     (push),
    .cmd      (push_cmd)
  );

  nfa_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  nfa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .out_ch   (out_chan)
  );

endmodule

FILE: design/nfa_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, decodes them into commands and drops no-op requests.
module nfa_front import nfa_pkg::*; (
  input  logic      clearing,
  input  logic      q_full,
  nfa_in_if.sink    in_ch,
  output logic      push,
  output cmd_t      cmd
);

  logic take;
  logic keep;
  logic in_range;

  assign in_ch.ready = !q_full && !clearing;
  assign take        = in_ch.valid && in_ch.ready;
  assign in_range    = (int'(in_ch.from_state) < NUM_STATES) &&
                       (int'(in_ch.to_state) < NUM_STATES);

  always_comb begin
    cmd.from_st = ST_W'(in_ch.from_state);
    cmd.to_st   = ST_W'(in_ch.to_state);
    cmd.sym     = in_ch.symbol[SYMBOL_BITS-1:0];
    cmd.last    = in_ch.last_symbol;
    cmd.op      = OP_LOAD;
    keep        = 1'b0;
    unique case (req_t'(in_ch.req_type))
      REQ_LOAD: begin
        cmd.op = OP_LOAD;
        keep   = in_range;
      end
      REQ_START: begin
        cmd.op = OP_START;
        keep   = 1'b1;
      end
      REQ_STEP: begin
        cmd.op = OP_STEP;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = take && keep;

endmodule

FILE: design/nfa_cmd_q.sv
`timescale 1ns / 1ps
// Command queue between front end and back end.
module nfa_cmd_q import nfa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = q_mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/nfa_back.sv
`timescale 1ns / 1ps
// Back end: transition store, active set sequencer and result register.
module nfa_back import nfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  cmd_t      head,
  output logic      pop,
  output logic      clearing,
  nfa_out_if.source out_ch
);

  logic [NUM_STATES-1:0] store_mem [STORE_DEPTH];

  bk_state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [NUM_STATES-1:0] active_r, active_nxt;
  logic [NUM_STATES-1:0] acc_r, acc_nxt;
  logic [ST_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [ST_W-1:0]       rd_idx_r, rd_idx_nxt;
  cmd_t                  cur_r, cur_nxt;
  logic [NUM_STATES-1:0] rd_data_r;

  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  we;
  logic [ADDR_W-1:0]     wa;
  logic [NUM_STATES-1:0] wd;
  logic [NUM_STATES-1:0] contrib;

  logic                  out_valid_r;
  logic                  out_accepted_r;
  logic [OUT_SET_W-1:0]  out_active_r;
  logic                  out_free;
  logic                  out_load;

  assign clearing = (state_r == BK_CLEAR);
  assign contrib  = active_r[rd_idx_r] ? rd_data_r : '0;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == BK_REPORT) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: begin
        if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          unique case (head.op)
            OP_LOAD:  state_nxt = BK_LOAD_WR;
            OP_START: state_nxt = head.last ? BK_REPORT : BK_IDLE;
            OP_STEP:  state_nxt = BK_SCAN;
            default:  state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_LOAD_WR: state_nxt = BK_IDLE;
      BK_SCAN: begin
        if (scan_idx_r == ST_W'(NUM_STATES - 1)) state_nxt = BK_DRAIN;
      end
      BK_DRAIN:  state_nxt = cur_r.last ? BK_REPORT : BK_IDLE;
      BK_REPORT: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    pop          = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    we           = 1'b0;
    wa           = '0;
    wd           = '0;
    clr_addr_nxt = clr_addr_r;
    active_nxt   = active_r;
    acc_nxt      = acc_r;
    scan_idx_nxt = scan_idx_r;
    rd_idx_nxt   = rd_idx_r;
    cur_nxt      = cur_r;
    unique case (state_r)
      BK_CLEAR: begin
        we           = 1'b1;
        wa           = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cur_nxt = head;
          unique case (head.op)
            OP_LOAD: begin
              rd_en   = 1'b1;
              rd_addr = {head.sym, head.from_st};
            end
            OP_START: begin
              active_nxt = init_set(cfg.init_st);
            end
            OP_STEP: begin
              rd_en        = 1'b1;
              rd_addr      = {head.sym, ST_W'(0)};
              rd_idx_nxt   = '0;
              scan_idx_nxt = ST_W'(1);
              acc_nxt      = '0;
            end
            default: begin
            end
          endcase
        end
      end
      BK_LOAD_WR: begin
        we = 1'b1;
        wa = {cur_r.sym, cur_r.from_st};
        wd = rd_data_r | (NUM_STATES'(1) << cur_r.to_st);
      end
      BK_SCAN: begin
        acc_nxt      = acc_r | contrib;
        rd_en        = 1'b1;
        rd_addr      = {cur_r.sym, scan_idx_r};
        rd_idx_nxt   = scan_idx_r;
        scan_idx_nxt = scan_idx_r + 1'b1;
      end
      BK_DRAIN: begin
        active_nxt = (acc_r | contrib) & keep_mask(cfg.highest);
      end
      BK_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      clr_addr_r <= '0;
      active_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      active_r   <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    cur_r      <= cur_nxt;
  end

  // transition store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_accepted_r <= |(active_r & NUM_STATES'(cfg.final_mask));
      out_active_r   <= OUT_SET_W'(active_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.accepted      = out_accepted_r;
  assign out_ch.active_states = out_active_r;

endmodule

FILE: design/nfa_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the NFA word acceptor, bound to the top level.
module nfa_chk import nfa_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_accepted,
  input logic [OUT_SET_W-1:0] out_active_states
);

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // store clearing pass follows reset: no words taken
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during store clear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_accepted) && $stable(out_active_states))
    else $error("result changed while stalled");

endmodule

bind nfa_word_acceptor_unit nfa_chk u_nfa_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_accepted      (out_chan.accepted),
  .out_active_states (out_chan.active_states)
);

FILE: bench/tb_nfa_word_acceptor_unit.sv
`timescale 1ns / 1ps
// Testbench for the NFA word acceptor: directed and random words checked against a predictor.
module tb_nfa_word_acceptor_unit import nfa_pkg::*;;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int WORD_TARGET   = 1050;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 400;
  localparam int STUCK_LIMIT   = 20000;

  typedef struct {
    logic [1:0]             kind;
    logic [FIELD_ST_W-1:0]  from_st;
    logic [FIELD_ST_W-1:0]  to_st;
    logic [FIELD_SYM_W-1:0] sym;
    logic                   last;
  } word_t;

  typedef struct {
    logic                 acc;
    logic [OUT_SET_W-1:0] states;
  } verdict_t;

  class word_verdicts;
    localparam int SYM_COUNT = 1 << SYMBOL_BITS;
    logic [NUM_STATES-1:0] succ [SYM_COUNT][NUM_STATES];
    logic [NUM_STATES-1:0] live;
    logic [FIELD_ST_W-1:0] init_st;
    logic [FIELD_ST_W-1:0] top_st;
    logic [CFG_W-1:0]      fin_mask;
    verdict_t              due[$];
    int                    errors;

    function new();
      foreach (succ[i, j]) succ[i][j] = '0;
      live     = '0;
      init_st  = '0;
      fin_mask = '0;
      top_st   = FIELD_ST_W'(15);
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_INITIAL: init_st = v[FIELD_ST_W-1:0];
        CFG_FINAL:   fin_mask = v;
        CFG_HIGHEST: top_st = v[FIELD_ST_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void absorb_word(word_t w);
      int sx;
      int h;
      logic [NUM_STATES-1:0] nxt;
      verdict_t vd;
      sx = int'(w.sym) % SYM_COUNT;
      if (w.kind == REQ_LOAD) begin
        if (int'(w.from_st) < NUM_STATES && int'(w.to_st) < NUM_STATES)
          succ[sx][w.from_st][w.to_st] = 1'b1;
        return;
      end
      if (w.kind == REQ_START) begin
        live = '0;
        if (int'(init_st) < NUM_STATES) live[init_st] = 1'b1;
      end else if (w.kind == REQ_STEP) begin
        nxt = '0;
        for (int s = 0; s < NUM_STATES; s++)
          if (live[s]) nxt |= succ[sx][s];
        h = (int'(top_st) > NUM_STATES - 1) ? NUM_STATES - 1 : int'(top_st);
        for (int s = 0; s < NUM_STATES; s++)
          if (s > h) nxt[s] = 1'b0;
        live = nxt;
      end else begin
        return;
      end
      if (w.last) begin
        vd.acc    = ((live & fin_mask) != '0);
        vd.states = live;
        due.push_back(vd);
      end
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task match_verdict(logic acc, logic [OUT_SET_W-1:0] states);
      verdict_t vd;
      if (due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: accepted %0b states %h", acc, states));
        return;
      end
      vd = due.pop_front();
      if (acc !== vd.acc)
        flag_mismatch($sformatf("accepted %0b, expected %0b", acc, vd.acc));
      if (states !== vd.states)
        flag_mismatch($sformatf("active_states %h, expected %h", states, vd.states));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  nfa_in_if  in_chan();
  nfa_out_if out_chan();

  nfa_word_acceptor_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  word_verdicts tracker;
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;
  int words_sent = 0;
  int stuck = 0;

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FIELD_ST_W-1:0] pick_state(logic [FIELD_ST_W-1:0] top);
    if ($urandom_range(0, 9) < 7) return FIELD_ST_W'($urandom_range(0, int'(top)));
    return FIELD_ST_W'($urandom);
  endfunction

  function automatic word_t word_of(logic [1:0] k, logic [FIELD_ST_W-1:0] f,
                                    logic [FIELD_ST_W-1:0] t, logic [FIELD_SYM_W-1:0] s,
                                    logic l);
    word_t w;
    w.kind    = k;
    w.from_st = f;
    w.to_st   = t;
    w.sym     = s;
    w.last    = l;
    return w;
  endfunction

  task automatic send_word(word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.req_type    <= w.kind;
    in_chan.from_state  <= w.from_st;
    in_chan.to_state    <= w.to_st;
    in_chan.symbol      <= w.sym;
    in_chan.last_symbol <= w.last;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    tracker.absorb_word(w);
    if (w.kind != REQ_UNUSED) words_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_reg(idx, v);
  endtask

  // drain results, then give queued no-result words time to finish
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    word_t w;
    logic [FIELD_SYM_W-1:0] alpha [4];
    logic [FIELD_ST_W-1:0] top;
    logic [CFG_W-1:0] v;
    int phase;
    int nloads;
    int nwords;
    int len;
    int r;
    tracker = new();
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.req_type    <= '0;
    in_chan.from_state  <= '0;
    in_chan.to_state    <= '0;
    in_chan.symbol      <= '0;
    in_chan.last_symbol <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_INITIAL;
    cfg_wdata           <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: symbol with no start, then an empty word
    send_word(word_of(REQ_STEP, 4'd0, 4'd0, 8'h00, 1'b1));
    send_word(word_of(REQ_START, 4'd0, 4'd0, 8'h00, 1'b1));
    settle();
    write_reg(CFG_INITIAL, 16'h0000);
    write_reg(CFG_FINAL, 16'h8001);
    write_reg(CFG_HIGHEST, 16'h000F);
    cfg_we <= 1'b0;
    send_word(word_of(REQ_UNUSED, 4'hF, 4'hF, 8'hFF, 1'b1));
    send_word(word_of(REQ_LOAD, 4'd0, 4'd1, 8'hFF, 1'b1));
    send_word(word_of(REQ_LOAD, 4'd0, 4'd1, 8'hFF, 1'b0));
    send_word(word_of(REQ_LOAD, 4'd1, 4'd15, 8'hFF, 1'b0));
    send_word(word_of(REQ_LOAD, 4'd15, 4'd0, 8'h00, 1'b0));
    send_word(word_of(REQ_LOAD, 4'd0, 4'd0, 8'h80, 1'b0));
    send_word(word_of(REQ_LOAD, 4'd10, 4'd5, 8'h55, 1'b0));
    send_word(word_of(REQ_START, 4'd0, 4'd0, 8'h00, 1'b1));
    send_word(word_of(REQ_START, 4'hA, 4'h5, 8'hAA, 1'b0));
    send_word(word_of(REQ_STEP, 4'd0, 4'd0, 8'hFF, 1'b0));
    send_word(word_of(REQ_STEP, 4'd0, 4'd0, 8'hFF, 1'b1));
    send_word(word_of(REQ_STEP, 4'd0, 4'd0, 8'h00, 1'b1));
    send_word(word_of(REQ_STEP, 4'd0, 4'd0, 8'h55, 1'b1));
    settle();
    // initial state above the highest state in use
    write_reg(CFG_INITIAL, 16'h000F);
    write_reg(CFG_HIGHEST, 16'hFFF0);
    write_reg(CFG_FINAL, 16'hFFFF);
    cfg_we <= 1'b0;
    send_word(word_of(REQ_START, 4'd0, 4'd0, 8'h00, 1'b1));
    send_word(word_of(REQ_START, 4'd0, 4'd0, 8'h00, 1'b0));
    send_word(word_of(REQ_STEP, 4'd0, 4'd0, 8'h00, 1'b1));
    send_word(word_of(REQ_STEP, 4'd0, 4'd0, 8'hFF, 1'b1));

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      settle();
      if (phase == 0) begin
        write_reg(CFG_INITIAL, 16'h0000);
        write_reg(CFG_FINAL, 16'hFFFF);
        write_reg(CFG_HIGHEST, 16'h000F);
      end else if (phase == 1) begin
        write_reg(CFG_INITIAL, 16'h5A5F);
        write_reg(CFG_FINAL, 16'h0000);
        write_reg(CFG_HIGHEST, 16'hA5A0);
      end else begin
        v = CFG_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 20) v[FIELD_ST_W-1:0] = '0;
        else if (r < 40) v[FIELD_ST_W-1:0] = '1;
        write_reg(CFG_INITIAL, v);
        v = CFG_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 15) v = '0;
        else if (r < 30) v = '1;
        write_reg(CFG_FINAL, v);
        v = CFG_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 20) v[FIELD_ST_W-1:0] = '1;
        else if (r < 35) v[FIELD_ST_W-1:0] = '0;
        write_reg(CFG_HIGHEST, v);
      end
      cfg_we <= 1'b0;
      top  = tracker.top_st;
      calm = ($urandom_range(0, 3) == 0);
      foreach (alpha[i]) alpha[i] = FIELD_SYM_W'($urandom);

      nloads = $urandom_range(4, 12);
      repeat (nloads)
        send_word(word_of(REQ_LOAD, pick_state(top), pick_state(top),
                          alpha[$urandom_range(0, 3)], 1'($urandom)));

      // receiver holds off while words keep coming
      if (phase == 2) long_hold_req = 1'b1;

      nwords = $urandom_range(5, 10);
      repeat (nwords) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_word(word_of(REQ_UNUSED, 4'($urandom), 4'($urandom), 8'($urandom),
                            1'($urandom)));
        end else if (r < 8) begin
          send_word(word_of(REQ_STEP, 4'($urandom), 4'($urandom), 8'($urandom),
                            1'($urandom)));
        end else if (r < 11) begin
          send_word(word_of(REQ_LOAD, 4'($urandom), 4'($urandom), 8'($urandom),
                            1'($urandom)));
        end else if (r < 19) begin
          send_word(word_of(REQ_START, 4'($urandom), 4'($urandom), 8'($urandom), 1'b1));
        end else begin
          // r below 24 leaves the word open
          send_word(word_of(REQ_START, 4'($urandom), 4'($urandom), 8'($urandom), 1'b0));
          len = $urandom_range(1, 6);
          for (int k = 1; k <= len; k++) begin
            w = word_of(REQ_STEP, 4'($urandom), 4'($urandom),
                        ($urandom_range(0, 99) < 85) ? alpha[$urandom_range(0, 3)]
                                                     : 8'($urandom),
                        (k == len) && (r >= 24));
            send_word(w);
          end
        end
      end
      phase++;
    end

    calm = 1'b0;
    settle();
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
        tracker.match_verdict(out_chan.accepted, out_chan.active_states);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

endmodule
